// ===== rtl/core/latency_histogram_percentile_unit_defines.svh =====
// Assertion macros shared by the latency histogram RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_UNIT_DEFINES_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LHP_AST_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define LHP_AST_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lhp_pkg.sv =====
// Shared types and constants of the latency histogram unit.
// No dependencies; used by lhp_div and latency_histogram_percentile_unit.
package lhp_pkg;

  localparam int VALUE_W    = 48;
  localparam int STATUS_W   = 2;
  localparam int TOTAL_W    = 42;
  localparam int PCT_W      = 10;
  localparam int PCT_SCALE  = 1000;
  localparam int MAX_SHIFT  = 31;

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_READ   = 3'd1,
    CMD_PCT    = 3'd2,
    CMD_MEDIAN = 3'd3,
    CMD_AVG    = 3'd4,
    CMD_MIN    = 3'd5,
    CMD_MAX    = 3'd6,
    CMD_IGNORE = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic {
    CFG_MIN_LATENCY = 1'b0,
    CFG_BIN_WIDTH   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/latency_histogram_percentile_unit.sv =====
// Latency histogram top level: bin store, scan pipeline and query control.
// Depends on lhp_pkg, lhp_div and the assertion macro header.
//
//  channel | signals                                          | direction
//  in      | in_valid/in_ready, command, sample, index, pct   | input beats
//  out     | out_valid/out_ready, out_value, out_status       | result beats
//  cfg     | cfg_we, cfg_index, cfg_wdata                     | register writes
//
// Add: one read-modify-write of the bin memory. Read bin: one read of the bin memory.
// Min/max/median/average/percentile: one scan over the memory read port;
// median and percentile add a second scan, average a serial division.
// After reset the bin memory is cleared, with in_ready low.
// A waiting result is held in the output register while the next beat enters.
`include "latency_histogram_percentile_unit_defines.svh"

module latency_histogram_percentile_unit #(
  parameter int NUM_BINS    = 1024,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       in_command,
  input  logic [31:0]                      in_sample,
  input  logic [15:0]                      in_bin_index,
  input  logic [lhp_pkg::PCT_W-1:0]        in_percentile_tenths,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [lhp_pkg::VALUE_W-1:0]      out_value,
  output logic [lhp_pkg::STATUS_W-1:0]     out_status,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [31:0]                      cfg_wdata
);

  localparam int IDX_W  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int SUM_W  = COUNT_WIDTH + IDX_W;
  localparam int S_W    = SUM_W + IDX_W;
  localparam int DVD_W  = S_W + lhp_pkg::MAX_SHIFT;
  localparam int DVS_W  = (SUM_W > lhp_pkg::PCT_W) ? SUM_W : lhp_pkg::PCT_W;
  localparam int Q_W    = (SUM_W + 1 > lhp_pkg::VALUE_W) ? SUM_W + 1 : lhp_pkg::VALUE_W;
  localparam int PW     = SUM_W + lhp_pkg::PCT_W;
  localparam int VW     = lhp_pkg::VALUE_W;
  localparam int TW     = lhp_pkg::TOTAL_W;

  typedef enum logic [10:0] {
    ST_CLEAR = 11'b000_0000_0001,
    ST_IDLE  = 11'b000_0000_0010,
    ST_ADD   = 11'b000_0000_0100,
    ST_RDBIN = 11'b000_0000_1000,
    ST_SCAN  = 11'b000_0001_0000,
    ST_DRAIN = 11'b000_0010_0000,
    ST_PMUL  = 11'b000_0100_0000,
    ST_DIV   = 11'b000_1000_0000,
    ST_DIVW  = 11'b001_0000_0000,
    ST_FIN   = 11'b010_0000_0000,
    ST_RESP  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0] mem [NUM_BINS];
  logic [COUNT_WIDTH-1:0] rd_data_r;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  logic [COUNT_WIDTH-1:0] mem_wd;

  logic [31:0]            min_r;
  logic [4:0]             bw_r;
  logic [TW-1:0]          total_r;

  lhp_pkg::cmd_t          cmd_in;
  lhp_pkg::cmd_t          cmd_r;
  logic [lhp_pkg::PCT_W-1:0] pct_r;
  logic [IDX_W-1:0]       add_bin_r;
  logic [IDX_W-1:0]       clr_addr_r;
  logic [IDX_W-1:0]       scan_addr_r;
  logic                   pass2_r;
  logic                   s1_vld_r, s2_vld_r;
  logic [IDX_W-1:0]       s1_idx_r;
  logic [SUM_W-1:0]       sum_r, run_r, run_nxt;
  logic [S_W-1:0]         asum_r;
  logic [IDX_W+COUNT_WIDTH-1:0] prod_r;
  logic                   nz_r, found_r;
  logic [IDX_W-1:0]       min_idx_r, max_idx_r, found_idx_r;
  logic [PW-1:0]          tgt_r;
  logic [PW-1:0]          pmul;
  logic [PW-1:0]          run_cmp;

  logic [31:0]            diff;
  logic [31:0]            bin_full;
  logic                   bin_ok;
  logic                   idx_ok;
  logic                   accept;
  logic                   scan_last;

  logic                   div_start;
  logic [DVD_W-1:0]       div_dvd;
  logic [DVS_W-1:0]       div_dvs;
  lhp_pkg::div_stat_t     div_stat;
  logic [Q_W-1:0]         div_quo;

  logic [IDX_W:0]         edge_idx;
  logic [VW-1:0]          edge_val;

  logic [VW-1:0]          res_value_r;
  lhp_pkg::status_t       res_status_r;
  logic                   out_valid_r;
  logic [VW-1:0]          out_value_r;
  lhp_pkg::status_t       out_status_r;

  assign cmd_in    = lhp_pkg::cmd_t'(in_command);
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign diff      = in_sample - min_r;
  assign bin_full  = diff >> bw_r;
  assign bin_ok    = (in_sample >= min_r) && (bin_full < 32'(NUM_BINS));
  assign idx_ok    = {1'b0, in_bin_index} < 17'(NUM_BINS);
  assign scan_last = scan_addr_r == IDX_W'(NUM_BINS - 1);
  assign run_nxt   = run_r + SUM_W'(rd_data_r);
  assign pmul      = PW'(pct_r) * PW'(sum_r);
  // percentile compares 1000 * running count against the scaled product
  assign run_cmp   = (cmd_r == lhp_pkg::CMD_PCT) ?
                     PW'(run_nxt) * PW'(lhp_pkg::PCT_SCALE) : PW'(run_nxt);

  // read address: the beat's bin or index in idle, the scan pointer otherwise
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_addr = (cmd_in == lhp_pkg::CMD_ADD) ? bin_full[IDX_W-1:0] : in_bin_index[IDX_W-1:0];
    end else begin
      rd_addr = scan_addr_r;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = add_bin_r;
    mem_wd = rd_data_r + COUNT_WIDTH'(1);
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
      mem_wd = '0;
    end else if (state_r == ST_ADD) begin
      mem_we = rd_data_r != {COUNT_WIDTH{1'b1}};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    priority case (cmd_r)
      lhp_pkg::CMD_MIN: edge_idx = {1'b0, min_idx_r};
      lhp_pkg::CMD_MAX: edge_idx = {1'b0, max_idx_r} + (IDX_W+1)'(1);
      default:          edge_idx = found_r ? {1'b0, found_idx_r} : (IDX_W+1)'(NUM_BINS);
    endcase
    edge_val = VW'(min_r) + (VW'(edge_idx) << bw_r);
  end

  assign div_start = (state_r == ST_DIV);
  assign div_dvd   = DVD_W'(asum_r) << bw_r;
  assign div_dvs   = DVS_W'(sum_r);

  lhp_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W),
    .Q_W   (Q_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == IDX_W'(NUM_BINS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            lhp_pkg::CMD_ADD:    state_nxt = bin_ok ? ST_ADD : ST_IDLE;
            lhp_pkg::CMD_READ:   state_nxt = idx_ok ? ST_RDBIN : ST_RESP;
            lhp_pkg::CMD_IGNORE: state_nxt = ST_IDLE;
            default:             state_nxt = (total_r == '0) ? ST_RESP : ST_SCAN;
          endcase
        end
      end
      ST_ADD:   state_nxt = ST_IDLE;
      ST_RDBIN: state_nxt = ST_RESP;
      ST_SCAN: begin
        if (scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r) begin
          if (pass2_r) begin
            state_nxt = ST_FIN;
          end else begin
            priority case (cmd_r)
              lhp_pkg::CMD_MEDIAN: state_nxt = ST_SCAN;
              lhp_pkg::CMD_PCT:    state_nxt = ST_PMUL;
              lhp_pkg::CMD_AVG:    state_nxt = ST_DIV;
              default:             state_nxt = ST_FIN;
            endcase
          end
        end
      end
      ST_PMUL: state_nxt = ST_SCAN;
      ST_DIV:  state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (div_stat.done) state_nxt = ST_RESP;
      end
      ST_FIN:  state_nxt = ST_RESP;
      ST_RESP: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      min_r       <= '0;
      bw_r        <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= (state_r == ST_SCAN);
      s2_vld_r <= s1_vld_r && !pass2_r;
      if (state_r == ST_CLEAR) clr_addr_r <= clr_addr_r + IDX_W'(1);
      if (cfg_we) begin
        unique case (lhp_pkg::cfg_idx_t'(cfg_index))
          lhp_pkg::CFG_MIN_LATENCY: min_r <= cfg_wdata;
          lhp_pkg::CFG_BIN_WIDTH:   bw_r  <= cfg_wdata[4:0];
          default:                  min_r <= min_r;
        endcase
      end
      if (mem_we && state_r == ST_ADD && total_r != {TW{1'b1}}) total_r <= total_r + TW'(1);
      if (state_r == ST_RESP && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= cmd_in;
      pct_r     <= in_percentile_tenths;
      add_bin_r <= bin_full[IDX_W-1:0];
      scan_addr_r <= '0;
      pass2_r   <= 1'b0;
      sum_r     <= '0;
      asum_r    <= '0;
      run_r     <= '0;
      nz_r      <= 1'b0;
      found_r   <= 1'b0;
      res_value_r  <= '0;
      if (cmd_in == lhp_pkg::CMD_READ) begin
        res_status_r <= idx_ok ? lhp_pkg::STS_OK : lhp_pkg::STS_BAD_INDEX;
      end else begin
        res_status_r <= lhp_pkg::STS_EMPTY;
      end
    end else begin
      if (state_r == ST_SCAN) scan_addr_r <= scan_addr_r + IDX_W'(1);
      if (state_r == ST_RDBIN) res_value_r <= VW'(rd_data_r);
      if (s1_vld_r) begin
        if (!pass2_r) begin
          sum_r  <= sum_r + SUM_W'(rd_data_r);
          prod_r <= s1_idx_r * rd_data_r;
          if (rd_data_r != '0) begin
            if (!nz_r) min_idx_r <= s1_idx_r;
            max_idx_r <= s1_idx_r;
            nz_r      <= 1'b1;
          end
        end else begin
          run_r <= run_nxt;
          if (!found_r && run_cmp >= tgt_r) begin
            found_r     <= 1'b1;
            found_idx_r <= s1_idx_r;
          end
        end
      end
      if (s2_vld_r) asum_r <= asum_r + S_W'(prod_r);
      if (state_r == ST_DRAIN && !s1_vld_r && !s2_vld_r && !pass2_r &&
          cmd_r == lhp_pkg::CMD_MEDIAN) begin
        tgt_r       <= PW'(sum_r >> 1);
        pass2_r     <= 1'b1;
        scan_addr_r <= '0;
      end
      // running count reaches floor(p * sum / 1000) when 1000 * run >= p * sum - 999
      if (state_r == ST_PMUL) begin
        tgt_r       <= (pmul >= PW'(lhp_pkg::PCT_SCALE - 1)) ?
                       pmul - PW'(lhp_pkg::PCT_SCALE - 1) : '0;
        pass2_r     <= 1'b1;
        scan_addr_r <= '0;
      end
      if (state_r == ST_DIVW && div_stat.done) begin
        res_value_r  <= VW'(min_r) + div_quo[VW-1:0];
        res_status_r <= lhp_pkg::STS_OK;
      end
      if (state_r == ST_FIN) begin
        res_value_r  <= edge_val;
        res_status_r <= lhp_pkg::STS_OK;
      end
    end
    s1_idx_r <= scan_addr_r;
    if (state_r == ST_RESP && (!out_valid_r || out_ready)) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  `LHP_AST_IMP(a_clear_blocks, clk, rst_n, state_r == ST_CLEAR, !in_ready, "input taken during clear")
  `LHP_AST_IMP(a_add_origin, clk, rst_n, state_r == ST_ADD, $past(accept), "add write without a beat")
  `LHP_AST_IMP(a_out_from_resp, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_RESP), "result without response state")
  `LHP_AST_IMP(a_div_idle_start, clk, rst_n, state_r == ST_DIV, !div_stat.busy, "division started while busy")

endmodule

// ===== rtl/core/lhp_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
// Depends on lhp_pkg (div_stat_t) and the assertion macro header.
`include "latency_histogram_percentile_unit_defines.svh"

module lhp_div #(
  parameter int DVD_W = 95,
  parameter int DVS_W = 48,
  parameter int Q_W   = 49
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output lhp_pkg::div_stat_t  stat,
  output logic [Q_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [Q_W-1:0]   quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic             ge;
  logic [DVS_W:0]   rem_sub;

  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[Q_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

  `LHP_AST_IMP(a_start_idle, clk, rst_n, start, !busy_r, "divider started while busy")
  `LHP_AST_NXT(a_start_busy, clk, rst_n, start, busy_r, "divider did not go busy")
  `LHP_AST_IMP(a_done_after, clk, rst_n, done_r, $past(busy_r), "done without a running division")

endmodule

// ===== tb/sv/latency_histogram_percentile_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for latency_histogram_percentile_unit: random adds and queries.
// Depends on lhp_pkg and the unit; predicts every query result from a histogram scoreboard.

module latency_histogram_percentile_unit_test;

  localparam int BINS = 1024;
  localparam int LIMIT = 20000000;

  typedef struct {
    logic [lhp_pkg::VALUE_W-1:0] value;
    lhp_pkg::status_t status;
  } query_answer_t;

  class histogram_scoreboard;
    bit [31:0] bin_count[BINS];
    logic [41:0] sample_total;
    logic [31:0] floor_latency;
    logic [4:0] width_log2;
    query_answer_t answers[$];
    int mismatches;

    function new();
      foreach (bin_count[i]) bin_count[i] = 0;
      sample_total = 0;
      floor_latency = 0;
      width_log2 = 0;
      mismatches = 0;
    endfunction

    function logic [63:0] bin_edge(int unsigned i);
      return {32'd0, floor_latency} + (64'(i) << width_log2);
    endfunction

    function logic [63:0] first_reaching(logic [63:0] target);
      logic [63:0] run;
      run = 0;
      for (int i = 0; i < BINS; i++) begin
        run += bin_count[i];
        if (run >= target) return bin_edge(i);
      end
      return bin_edge(BINS);
    endfunction

    function void note_beat(logic [2:0] code, logic [31:0] smp, logic [15:0] idx,
                            logic [9:0] pct);
      query_answer_t a;
      logic [63:0] bin, sum, weighted, v;
      logic [127:0] scaled;
      lhp_pkg::cmd_t c;
      c = lhp_pkg::cmd_t'(code);
      if (c == lhp_pkg::CMD_ADD) begin
        if (smp < floor_latency) return;
        bin = 64'(smp - floor_latency) >> width_log2;
        if (bin >= BINS) return;
        if (bin_count[bin] != 32'hFFFF_FFFF) begin
          bin_count[bin]++;
          if (sample_total != {42{1'b1}}) sample_total++;
        end
        return;
      end
      if (c == lhp_pkg::CMD_IGNORE) return;
      v = 0;
      a.status = lhp_pkg::STS_OK;
      if (c == lhp_pkg::CMD_READ) begin
        if (idx < BINS) v = bin_count[idx];
        else a.status = lhp_pkg::STS_BAD_INDEX;
      end else if (sample_total == 0) begin
        a.status = lhp_pkg::STS_EMPTY;
      end else begin
        sum = 0;
        weighted = 0;
        for (int i = 0; i < BINS; i++) begin
          sum += bin_count[i];
          weighted += 64'(i) * bin_count[i];
        end
        case (c)
          lhp_pkg::CMD_PCT: v = first_reaching(64'(pct) * sum / lhp_pkg::PCT_SCALE);
          lhp_pkg::CMD_MEDIAN: v = first_reaching(sum / 2);
          lhp_pkg::CMD_AVG: begin
            scaled = (128'(weighted) << width_log2) / sum;
            v = {32'd0, floor_latency} + scaled[63:0];
          end
          lhp_pkg::CMD_MIN: begin
            for (int i = 0; i < BINS; i++)
              if (bin_count[i] != 0) begin
                v = bin_edge(i);
                break;
              end
          end
          default: begin
            for (int i = BINS; i > 0; i--)
              if (bin_count[i-1] != 0) begin
                v = bin_edge(i);
                break;
              end
          end
        endcase
      end
      a.value = v[lhp_pkg::VALUE_W-1:0];
      answers.push_back(a);
    endfunction

    function void check_beat(logic [lhp_pkg::VALUE_W-1:0] value,
                             logic [lhp_pkg::STATUS_W-1:0] status);
      query_answer_t a;
      if (answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: value %0d status %0d", value, status);
        return;
      end
      a = answers.pop_front();
      if (value !== a.value || status !== a.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                   a.value, a.status, value, status);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [2:0] in_command = 0;
  logic [31:0] in_sample = 0;
  logic [15:0] in_bin_index = 0;
  logic [lhp_pkg::PCT_W-1:0] in_percentile_tenths = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [lhp_pkg::VALUE_W-1:0] out_value;
  logic [lhp_pkg::STATUS_W-1:0] out_status;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [31:0] cfg_wdata = 0;

  histogram_scoreboard hist = new();
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 0;
  int cycles = 0;

  latency_histogram_percentile_unit dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready) hist.check_beat(out_value, out_status);
      if (in_valid && in_ready)
        hist.note_beat(in_command, in_sample, in_bin_index, in_percentile_tenths);
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 4000;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // call at a falling edge; returns at a falling edge
  task automatic send_beat(lhp_pkg::cmd_t c, logic [31:0] smp, logic [15:0] idx,
                           logic [9:0] pct);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_command = c;
    in_sample = smp;
    in_bin_index = idx;
    in_percentile_tenths = pct;
    in_valid = 1;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain();
    in_valid = 0;
    while (hist.answers.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(lhp_pkg::cfg_idx_t r, logic [31:0] data);
    cfg_we = 1;
    cfg_index = r;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 0;
    if (r == lhp_pkg::CFG_MIN_LATENCY) hist.floor_latency = data;
    else hist.width_log2 = data[4:0];
  endtask

  task automatic random_beat();
    logic [63:0] span;
    logic [31:0] smp;
    logic [15:0] idx;
    logic [9:0] pct;
    int roll;
    lhp_pkg::cmd_t c;
    span = 64'(BINS) << hist.width_log2;
    if (span > 64'h1_0000_0000 - hist.floor_latency)
      span = 64'h1_0000_0000 - hist.floor_latency;
    if ($urandom_range(99) < 85)
      smp = hist.floor_latency + 32'($urandom_range(0, 32'(span - 1)));
    else
      smp = $urandom;
    idx = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(BINS - 1));
    pct = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(1000));
    roll = $urandom_range(99);
    if (roll < 82) c = lhp_pkg::CMD_ADD;
    else if (roll < 84) c = lhp_pkg::CMD_IGNORE;
    else c = lhp_pkg::cmd_t'($urandom_range(1, 6));
    send_beat(c, smp, idx, pct);
  endtask

  initial begin
    logic [31:0] mins[6];
    logic [4:0] widths[6];
    mins = '{32'd100, 32'd0, 32'hFFFF_FC00, 32'd0, 32'h1234_5678, 32'hFFFF_FFFF};
    widths = '{5'd0, 5'd3, 5'd0, 5'd31, 5'd16, 5'd5};
    repeat (11) @(negedge clk);
    rst_n = 1;

    for (int c = 1; c <= 7; c++) send_beat(lhp_pkg::cmd_t'(c), 0, 0, 10'd500);
    send_beat(lhp_pkg::CMD_READ, 0, 16'd1023, 0);
    send_beat(lhp_pkg::CMD_READ, 0, 16'd1024, 0);
    send_beat(lhp_pkg::CMD_READ, 0, 16'hFFFF, 0);
    drain();
    write_reg(lhp_pkg::CFG_MIN_LATENCY, 32'd100);
    send_beat(lhp_pkg::CMD_ADD, 32'd99, 0, 0);
    send_beat(lhp_pkg::CMD_ADD, 32'd100, 0, 0);
    send_beat(lhp_pkg::CMD_ADD, 32'd1123, 0, 0);
    send_beat(lhp_pkg::CMD_ADD, 32'd1124, 0, 0);
    send_beat(lhp_pkg::CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, 10'h3FF);
    send_beat(lhp_pkg::CMD_PCT, 0, 0, 10'd0);
    send_beat(lhp_pkg::CMD_PCT, 0, 0, 10'd1000);
    send_beat(lhp_pkg::CMD_PCT, 0, 0, 10'd1023);
    for (int c = 3; c <= 6; c++) send_beat(lhp_pkg::cmd_t'(c), 0, 0, 0);
    send_beat(lhp_pkg::CMD_READ, 0, 16'd0, 0);
    send_beat(lhp_pkg::CMD_READ, 0, 16'd1023, 0);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_reg(lhp_pkg::CFG_MIN_LATENCY, mins[ph]);
      write_reg(lhp_pkg::CFG_BIN_WIDTH, {27'd0, widths[ph]});
      case (ph % 4)
        0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
        1: begin sender_idle_pct = 84; receiver_stall_pct = 0; end
        2: begin sender_idle_pct = 0; receiver_stall_pct = 84; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
      if (ph == 1) hold_req = 1;
      for (int n = 0; n < 240; n++) begin
        if (ph == 2 && n == 120) drain();
        random_beat();
      end
    end
    drain();
    repeat (300) @(negedge clk);
    if (hist.mismatches == 0 && hist.answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
